### hdl/assert_macros.svh
// Assertion macros shared by the blur RTL.
// No dependencies; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is high.
`define GB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define GB_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/gbce_pkg.sv
// Shared constants, types and codes for the Gaussian blur core.
// No dependencies.
package gbce_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_RADIUS  = 3;
  localparam int WEIGHT_BITS = 16;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 12;
  localparam int ROW_SEL_W = $clog2(2 * MAX_RADIUS + 2);
  localparam int MEM_DEPTH = (1 << ROW_SEL_W) * MAX_WIDTH;
  localparam int MEM_AW    = ROW_SEL_W + COL_W;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int TAP_W     = $clog2(2 * MAX_RADIUS + 1);
  localparam int PROD_W    = 2 * WEIGHT_BITS;
  localparam int ACC_W     = PROD_W + CH_W
                             + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
  localparam int LIN_W     = 24;

  typedef enum logic [2:0] {
    REG_RADIUS = 3'd0,
    REG_W0     = 3'd1,
    REG_W1     = 3'd2,
    REG_W2     = 3'd3,
    REG_W3     = 3'd4,
    REG_WIDTH  = 3'd5,
    REG_HEIGHT = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAPS,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic add;
  } lane_ctrl_t;

endpackage

### hdl/gaussian_blur_clamped_edges_core.sv
// Streaming RGB Gaussian blur, square kernel of radius 0..3, edges clamped.
// Pixels come in raster order; r*W+r flush items after the frame drain it.
// An item that yields a pixel is written, then each window tap is read in turn
// on the single read port of the row store, then the multiply pipeline is
// emptied and the result handed to the output register, which can stall. Items
// in the start-up lag are only written. Weights are separable 1-D Q0.16 values;
// each tap weight is their product, the three colour lanes accumulate in
// parallel and the sum is rounded half up once and saturated to 255. The row
// store keeps eight rows of MAX_WIDTH pixels and needs no clearing after reset.
// Depends on gbce_pkg, gbce_ram, gbce_lane, gbce_merge and assert_macros.svh.
`include "assert_macros.svh"

module gaussian_blur_clamped_edges_core import gbce_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // pixel items in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        req_type,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  // blurred items out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        frame_last,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------- registers ----------------
  logic [1:0]             kernel_radius;
  logic [WEIGHT_BITS-1:0] weight [4];
  logic [11:0]            frame_width;
  logic [11:0]            frame_height;

  logic     cfg_wr;
  reg_idx_t cfg_idx;
  logic     geo_clear;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);
  assign geo_clear = cfg_wr & (cfg_idx == REG_RADIUS || cfg_idx == REG_WIDTH ||
                               cfg_idx == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_radius <= 2'd1;
      weight[0]     <= 16'd32768;
      weight[1]     <= 16'd16384;
      weight[2]     <= '0;
      weight[3]     <= '0;
      frame_width   <= 12'd640;
      frame_height  <= 12'd480;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_RADIUS: kernel_radius <= pwdata[1:0];
        REG_W0:     weight[0]     <= pwdata[WEIGHT_BITS-1:0];
        REG_W1:     weight[1]     <= pwdata[WEIGHT_BITS-1:0];
        REG_W2:     weight[2]     <= pwdata[WEIGHT_BITS-1:0];
        REG_W3:     weight[3]     <= pwdata[WEIGHT_BITS-1:0];
        REG_WIDTH:  frame_width   <= pwdata[11:0];
        REG_HEIGHT: frame_height  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_RADIUS: prdata = 32'(kernel_radius);
      REG_W0:     prdata = 32'(weight[0]);
      REG_W1:     prdata = 32'(weight[1]);
      REG_W2:     prdata = 32'(weight[2]);
      REG_W3:     prdata = 32'(weight[3]);
      REG_WIDTH:  prdata = 32'(frame_width);
      REG_HEIGHT: prdata = 32'(frame_height);
      default:    prdata = '0;
    endcase
  end

  // ---------------- effective geometry ----------------
  // width 0 acts as 1, above MAX_WIDTH as MAX_WIDTH; height 0 acts as 1
  logic [COL_W:0]   w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [LIN_W-1:0] frame_px;
  logic [LIN_W-1:0] lag;
  logic [TAP_W-1:0] r_ext;
  logic [TAP_W-1:0] r2;

  always_comb begin
    if (frame_width == '0) begin
      w_eff = (COL_W+1)'(1);
    end else if (frame_width > 12'(MAX_WIDTH)) begin
      w_eff = (COL_W+1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W+1)'(frame_width);
    end
    h_eff = (frame_height == '0) ? ROW_W'(1) : frame_height;
  end

  assign frame_px = LIN_W'(w_eff) * LIN_W'(h_eff);
  assign lag      = LIN_W'(kernel_radius) * LIN_W'(w_eff) + LIN_W'(kernel_radius);
  assign r_ext    = TAP_W'(kernel_radius);
  assign r2       = TAP_W'({kernel_radius, 1'b0});

  // ---------------- control ----------------
  state_t state, state_next;

  logic [COL_W-1:0] in_col;
  logic [ROW_W:0]   in_row;
  logic [LIN_W-1:0] lin;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [TAP_W-1:0] tap_x, tap_y;
  logic             drain_cnt;

  logic in_acc, last_tap, emits, load_out, is_last;

  assign in_ready = (state == ST_IDLE);
  assign in_acc   = in_valid & in_ready;
  assign emits    = lin >= lag;
  assign last_tap = (tap_x == r2) && (tap_y == r2);
  assign load_out = (state == ST_DONE) && (!out_valid || out_ready);
  assign is_last  = (out_row >= h_eff - ROW_W'(1)) &&
                    ((COL_W+1)'(out_col) >= w_eff - (COL_W+1)'(1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_acc && emits) state_next = ST_TAPS;
      ST_TAPS:  if (last_tap) state_next = ST_DRAIN;
      ST_DRAIN: if (drain_cnt) state_next = ST_DONE;
      ST_DONE:  if (load_out) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // tap walk and drain count
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_x     <= '0;
      tap_y     <= '0;
      drain_cnt <= 1'b0;
    end else begin
      if (in_acc) begin
        tap_x <= '0;
        tap_y <= '0;
      end else if (state == ST_TAPS) begin
        if (tap_x == r2) begin
          tap_x <= '0;
          tap_y <= tap_y + TAP_W'(1);
        end else begin
          tap_x <= tap_x + TAP_W'(1);
        end
      end
      drain_cnt <= (state == ST_DRAIN) ? ~drain_cnt : 1'b0;
    end
  end

  // raster counters; geometry writes and frame end start a new frame
  always_ff @(posedge clk) begin
    if (rst || geo_clear) begin
      in_col  <= '0;
      in_row  <= '0;
      lin     <= '0;
      out_col <= '0;
      out_row <= '0;
    end else if (load_out && is_last) begin
      in_col  <= '0;
      in_row  <= '0;
      lin     <= '0;
      out_col <= '0;
      out_row <= '0;
    end else begin
      if (in_acc) begin
        lin <= lin + LIN_W'(1);
        if ((COL_W+1)'(in_col) + (COL_W+1)'(1) >= w_eff) begin
          in_col <= '0;
          in_row <= in_row + (ROW_W+1)'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (load_out) begin
        if ((COL_W+1)'(out_col) + (COL_W+1)'(1) >= w_eff) begin
          out_col <= '0;
          out_row <= out_row + ROW_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  // ---------------- row store ----------------
  // eight rows kept, addressed by row modulo eight and column
  logic              mem_we;
  logic [MEM_AW-1:0] waddr, raddr;
  logic [PIX_W-1:0]  wdata, rdata;

  assign mem_we = in_acc && (lin < frame_px);
  assign waddr  = {in_row[ROW_SEL_W-1:0], in_col};
  assign wdata  = req_type ? '0 : {in_blue, in_green, in_red};

  // clamped tap position
  logic [COL_W+2:0] vx;
  logic [ROW_W+1:0] vy;
  logic [COL_W-1:0] nx;
  logic [ROW_W-1:0] ny;
  logic [TAP_W-1:0] dx, dy;

  always_comb begin
    vx = (COL_W+3)'(out_col) + (COL_W+3)'(tap_x) - (COL_W+3)'(r_ext);
    vy = (ROW_W+2)'(out_row) + (ROW_W+2)'(tap_y) - (ROW_W+2)'(r_ext);
    if (vx[COL_W+2]) begin
      nx = '0;
    end else if (vx[COL_W+1:0] >= (COL_W+2)'(w_eff)) begin
      nx = COL_W'(w_eff - (COL_W+1)'(1));
    end else begin
      nx = vx[COL_W-1:0];
    end
    if (vy[ROW_W+1]) begin
      ny = '0;
    end else if (vy[ROW_W:0] >= (ROW_W+1)'(h_eff)) begin
      ny = h_eff - ROW_W'(1);
    end else begin
      ny = vy[ROW_W-1:0];
    end
    dx = (tap_x >= r_ext) ? tap_x - r_ext : r_ext - tap_x;
    dy = (tap_y >= r_ext) ? tap_y - r_ext : r_ext - tap_y;
  end

  assign raddr = {ny[ROW_SEL_W-1:0], nx};

  gbce_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // ---------------- tap pipeline ----------------
  // stage 1: read data back, 1-D weights; stage 2: product weight
  logic                   v1, v2;
  logic [WEIGHT_BITS-1:0] wx1, wy1;
  logic [PROD_W-1:0]      wt2;
  logic [PIX_W-1:0]       pix2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == ST_TAPS);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    wx1  <= dx[TAP_W-1] ? '0 : weight[dx[1:0]];
    wy1  <= dy[TAP_W-1] ? '0 : weight[dy[1:0]];
    wt2  <= wx1 * wy1;
    pix2 <= rdata;
  end

  // ---------------- colour lanes and merge ----------------
  lane_ctrl_t       lane_ctrl;
  logic [ACC_W-1:0] acc [3];
  logic [CH_W-1:0]  chan [3];

  assign lane_ctrl.clear = in_acc;
  assign lane_ctrl.add   = v2;

  for (genvar c = 0; c < 3; c++) begin : g_lane
    gbce_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .pix  (pix2[c*CH_W +: CH_W]),
      .wt   (wt2),
      .acc  (acc[c])
    );
  end

  gbce_merge u_merge (
    .acc  (acc),
    .chan (chan)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_red    <= chan[0];
      out_green  <= chan[1];
      out_blue   <= chan[2];
      frame_last <= is_last;
    end
  end

  // ---------------- checks ----------------
  `GB_ASSERT(a_done_loads, (state == ST_DONE && !(out_valid && !out_ready)) |=> out_valid, "result not loaded")
  `GB_ASSERT(a_no_add_idle, (state == ST_IDLE) |-> !v2, "lane add while idle")
  `GB_ASSERT(a_tap_bound, (state == ST_TAPS) |-> (tap_x <= r2 && tap_y <= r2), "tap beyond window")
endmodule

### hdl/gbce_ram.sv
// Generic simple dual-port RAM with registered read.
// No dependencies.
module gbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/gbce_lane.sv
// One colour lane: weighted multiply-accumulate over the window taps.
// Depends on gbce_pkg.
module gbce_lane import gbce_pkg::*; (
  input  logic              clk,
  input  lane_ctrl_t        ctrl,
  input  logic [CH_W-1:0]   pix,
  input  logic [PROD_W-1:0] wt,
  output logic [ACC_W-1:0]  acc
);
  logic [CH_W+PROD_W-1:0] prod;

  assign prod = pix * wt;

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.add) begin
      acc <= acc + ACC_W'(prod);
    end
  end
endmodule

### hdl/gbce_merge.sv
// Merge of the three lane sums: round half up, drop fraction, saturate.
// Depends on gbce_pkg.
module gbce_merge import gbce_pkg::*; (
  input  logic [ACC_W-1:0] acc [3],
  output logic [CH_W-1:0]  chan [3]
);
  logic [ACC_W:0]        rnd [3];
  logic [ACC_W-PROD_W:0] whole [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c]   = (ACC_W+1)'(acc[c]) + ((ACC_W+1)'(1) << (PROD_W - 1));
      whole[c] = rnd[c][ACC_W:PROD_W];
      chan[c]  = (whole[c] > (ACC_W-PROD_W+1)'(255)) ? 8'hFF : whole[c][CH_W-1:0];
    end
  end
endmodule
